// File: hdl/c2r_pkg.sv
// c2r_pkg: shared widths, latencies, angle table and stage structs
package c2r_pkg;

    localparam int WORD_W      = 32;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int RHO_W       = 32;
    localparam int BEAR_W      = 19;
    localparam int RATE_W      = 33;
    localparam int Q_W         = 33;
    localparam int ANG_W       = 34;
    localparam int ANG_FRAC    = 30;
    localparam int OUT_FRAC    = 16;
    localparam int CX_W        = 64;
    localparam int NORM_W      = 58;
    localparam int PRE_SHIFT   = 26;
    localparam int NORM_STEPS  = 5;
    localparam int CORDIC_STEPS = 31;
    localparam int SQRT_STEPS  = 32;
    localparam int REM_W       = 34;
    localparam int SQRT_LAT    = SQRT_STEPS + 1;
    localparam int DIV_LAT     = Q_W + 1;
    localparam int CORDIC_LAT  = 1 + NORM_STEPS + CORDIC_STEPS + 1;
    localparam int BEAR_DLY    = SQRT_LAT + DIV_LAT - CORDIC_LAT;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] BEAR_LIM    = 34'sd205888;
    localparam logic [Q_W-1:0]          RATE_LIM    = 33'd3037000500;

    localparam logic [29:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
        30'h00000001
    };

    typedef struct packed {
        logic             valid;
        logic [RHO_W-1:0] rho;
        logic [PROD_W-1:0] dmag;
        logic             neg;
        logic             zero;
    } t_sq_out;

    typedef struct packed {
        logic             valid;
        logic [RHO_W-1:0] rho;
        logic [Q_W-1:0]   quo;
        logic             sat;
        logic             neg;
        logic             zero;
    } t_div_out;

endpackage

// File: hdl/c2r_in_if.sv
// c2r_in_if: measurement input channel
interface c2r_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [c2r_pkg::WORD_W-1:0] pos_x;
    logic signed [c2r_pkg::WORD_W-1:0] pos_y;
    logic signed [c2r_pkg::WORD_W-1:0] vel_x;
    logic signed [c2r_pkg::WORD_W-1:0] vel_y;
    modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

// File: hdl/c2r_out_if.sv
// c2r_out_if: polar result output channel
interface c2r_out_if;
    logic                              valid;
    logic                              ready;
    logic        [c2r_pkg::RHO_W-1:0]  range_out;
    logic signed [c2r_pkg::BEAR_W-1:0] bearing_out;
    logic signed [c2r_pkg::RATE_W-1:0] range_rate_out;
    logic                              range_zero;
    modport source (output valid, range_out, bearing_out, range_rate_out, range_zero,
                    input ready);
    modport sink (input valid, range_out, bearing_out, range_rate_out, range_zero,
                  output ready);
endinterface

// File: hdl/c2r_sqrt.sv
// c2r_sqrt: pipelined integer square root of the sum of squares, one root bit per stage
module c2r_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [c2r_pkg::PROD_W-1:0]   i_sq_x,
    input  logic [c2r_pkg::PROD_W-1:0]   i_sq_y,
    input  logic signed [c2r_pkg::PROD_W-1:0] i_p1,
    input  logic signed [c2r_pkg::PROD_W-1:0] i_p2,
    input  logic                         i_zero,
    output c2r_pkg::t_sq_out             o_sq
);
    import c2r_pkg::*;

    logic              r_v    [0:SQRT_STEPS];
    logic [PROD_W-1:0] r_s    [0:SQRT_STEPS];
    logic [RHO_W-1:0]  r_root [0:SQRT_STEPS];
    logic [REM_W-1:0]  r_rem  [0:SQRT_STEPS];
    logic [PROD_W-1:0] r_dmag [0:SQRT_STEPS];
    logic              r_neg  [0:SQRT_STEPS];
    logic              r_zero [0:SQRT_STEPS];

    logic signed [PROD_W:0] w_dsum;
    logic [PROD_W:0]        w_dabs;

    always_comb begin
        w_dsum = {i_p1[PROD_W-1], i_p1} + {i_p2[PROD_W-1], i_p2};
        w_dabs = w_dsum[PROD_W] ? (~w_dsum + 1'b1) : w_dsum;
    end

    // operand stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_s[0]    <= i_sq_x + i_sq_y;
            r_root[0] <= '0;
            r_rem[0]  <= '0;
            r_dmag[0] <= w_dabs[PROD_W-1:0];
            r_neg[0]  <= w_dsum[PROD_W];
            r_zero[0] <= i_zero;
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
        logic [REM_W+1:0] w_rt;
        logic [REM_W+1:0] w_trial;
        logic             w_ge;

        always_comb begin
            w_rt    = {r_rem[k-1], r_s[k-1][PROD_W-1 -: 2]};
            w_trial = {2'b00, r_root[k-1], 2'b01};
            w_ge    = (w_rt >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en) begin
                r_s[k]    <= {r_s[k-1][PROD_W-3:0], 2'b00};
                r_root[k] <= {r_root[k-1][RHO_W-2:0], w_ge};
                r_rem[k]  <= w_ge ? REM_W'(w_rt - w_trial) : w_rt[REM_W-1:0];
                r_dmag[k] <= r_dmag[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    assign o_sq.valid = r_v[SQRT_STEPS];
    assign o_sq.rho   = r_root[SQRT_STEPS];
    assign o_sq.dmag  = r_dmag[SQRT_STEPS];
    assign o_sq.neg   = r_neg[SQRT_STEPS];
    assign o_sq.zero  = r_zero[SQRT_STEPS];

endmodule

// File: hdl/c2r_div.sv
// c2r_div: pipelined restoring divider for range rate, one quotient bit per stage
module c2r_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  c2r_pkg::t_sq_out  i_sq,
    output c2r_pkg::t_div_out o_div
);
    import c2r_pkg::*;

    localparam int HI_W = PROD_W - Q_W;

    logic              r_v    [0:Q_W];
    logic [RHO_W-1:0]  r_rho  [0:Q_W];
    logic [RHO_W-1:0]  r_rem  [0:Q_W];
    logic [Q_W-1:0]    r_lo   [0:Q_W];
    logic [Q_W-1:0]    r_quo  [0:Q_W];
    logic              r_sat  [0:Q_W];
    logic              r_neg  [0:Q_W];
    logic              r_zero [0:Q_W];

    // quotient too wide for the clamp when the upper dividend bits reach the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_sq.valid;
        end
        if (i_en) begin
            r_rho[0]  <= i_sq.rho;
            r_rem[0]  <= RHO_W'(i_sq.dmag[PROD_W-1:Q_W]);
            r_lo[0]   <= i_sq.dmag[Q_W-1:0];
            r_quo[0]  <= '0;
            r_sat[0]  <= ({{(RHO_W-HI_W){1'b0}}, i_sq.dmag[PROD_W-1:Q_W]} >= i_sq.rho);
            r_neg[0]  <= i_sq.neg;
            r_zero[0] <= i_sq.zero;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [RHO_W:0] w_t;
        logic           w_ge;

        always_comb begin
            w_t  = {r_rem[k-1], r_lo[k-1][Q_W-1]};
            w_ge = (w_t >= {1'b0, r_rho[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en) begin
                r_rho[k]  <= r_rho[k-1];
                r_rem[k]  <= w_ge ? RHO_W'(w_t - {1'b0, r_rho[k-1]}) : w_t[RHO_W-1:0];
                r_lo[k]   <= {r_lo[k-1][Q_W-2:0], 1'b0};
                r_quo[k]  <= {r_quo[k-1][Q_W-2:0], w_ge};
                r_sat[k]  <= r_sat[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    assign o_div.valid = r_v[Q_W];
    assign o_div.rho   = r_rho[Q_W];
    assign o_div.quo   = r_quo[Q_W];
    assign o_div.sat   = r_sat[Q_W];
    assign o_div.neg   = r_neg[Q_W];
    assign o_div.zero  = r_zero[Q_W];

endmodule

// File: hdl/c2r_cordic.sv
// c2r_cordic: pipelined vectoring cordic for bearing with normalizer and delay alignment
module c2r_cordic (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [c2r_pkg::WORD_W-1:0] i_px,
    input  logic signed [c2r_pkg::WORD_W-1:0] i_py,
    output logic signed [c2r_pkg::BEAR_W-1:0] o_bearing
);
    import c2r_pkg::*;

    localparam int LAST = NORM_STEPS + CORDIC_STEPS;

    logic signed [CX_W-1:0]  r_x [0:LAST];
    logic signed [CX_W-1:0]  r_y [0:LAST];
    logic signed [ANG_W-1:0] r_z [0:LAST];
    logic [NORM_W-1:0]       r_m [0:NORM_STEPS];
    logic signed [BEAR_W-1:0] r_b;
    logic signed [BEAR_W-1:0] r_dly [0:BEAR_DLY-1];

    logic signed [WORD_W:0]  w_px;
    logic signed [WORD_W:0]  w_py;
    logic signed [WORD_W:0]  w_xr;
    logic signed [WORD_W:0]  w_yr;
    logic signed [ANG_W-1:0] w_zr;
    logic [WORD_W:0]         w_ax;
    logic [WORD_W:0]         w_ay;
    logic [WORD_W-1:0]       w_m;

    // turn into the right half plane
    always_comb begin
        w_px = {i_px[WORD_W-1], i_px};
        w_py = {i_py[WORD_W-1], i_py};
        w_xr = w_px;
        w_yr = w_py;
        w_zr = '0;
        if (i_px[WORD_W-1]) begin
            if (!i_py[WORD_W-1]) begin
                w_xr = w_py;
                w_yr = -w_px;
                w_zr = HALF_PI_Q30;
            end else begin
                w_xr = -w_py;
                w_yr = w_px;
                w_zr = -HALF_PI_Q30;
            end
        end
        w_ax = w_xr[WORD_W] ? -w_xr : w_xr;
        w_ay = w_yr[WORD_W] ? -w_yr : w_yr;
        w_m  = (w_ax > w_ay) ? w_ax[WORD_W-1:0] : w_ay[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CX_W'(w_xr) <<< PRE_SHIFT;
            r_y[0] <= CX_W'(w_yr) <<< PRE_SHIFT;
            r_z[0] <= w_zr;
            r_m[0] <= NORM_W'(w_m) << PRE_SHIFT;
        end
    end

    // leading one search, halving shift per stage
    for (genvar j = 1; j <= NORM_STEPS; j++) begin : g_norm
        localparam int D = (1 << NORM_STEPS) >> j;
        logic w_sh;

        assign w_sh = (r_m[j-1][NORM_W-1 -: D] == '0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j] <= w_sh ? (r_x[j-1] <<< D) : r_x[j-1];
                r_y[j] <= w_sh ? (r_y[j-1] <<< D) : r_y[j-1];
                r_z[j] <= r_z[j-1];
                r_m[j] <= w_sh ? (r_m[j-1] << D) : r_m[j-1];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        localparam int P = NORM_STEPS + i;
        logic                   w_up;
        logic signed [CX_W-1:0] w_xs;
        logic signed [CX_W-1:0] w_ys;

        always_comb begin
            w_up = (r_y[P] > 0);
            w_xs = r_x[P] >>> i;
            w_ys = r_y[P] >>> i;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_up) begin
                    r_x[P+1] <= r_x[P] + w_ys;
                    r_y[P+1] <= r_y[P] - w_xs;
                    r_z[P+1] <= r_z[P] + ANG_W'(ATAN_TAB[i]);
                end else begin
                    r_x[P+1] <= r_x[P] - w_ys;
                    r_y[P+1] <= r_y[P] + w_xs;
                    r_z[P+1] <= r_z[P] - ANG_W'(ATAN_TAB[i]);
                end
            end
        end
    end

    // round half up to output fraction and clamp
    logic signed [ANG_W-1:0] w_zrnd;

    assign w_zrnd = (r_z[LAST] + ANG_W'(1 << (ANG_FRAC - OUT_FRAC - 1)))
                    >>> (ANG_FRAC - OUT_FRAC);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_zrnd > BEAR_LIM) begin
                r_b <= BEAR_W'(BEAR_LIM);
            end else if (w_zrnd < -BEAR_LIM) begin
                r_b <= BEAR_W'(-BEAR_LIM);
            end else begin
                r_b <= w_zrnd[BEAR_W-1:0];
            end
        end
    end

    // align with the range rate path
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= r_b;
            for (int k = 1; k < BEAR_DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_bearing = r_dly[BEAR_DLY-1];

endmodule

// File: hdl/cartesian_to_range_bearing_rate_core.sv
// cartesian_to_range_bearing_rate_core: top level of the cartesian to polar converter
//
//  channel   direction  payload                                          transfer
//  i_meas    in         pos_x, pos_y, vel_x, vel_y                       valid & ready
//  o_res     out        range_out, bearing_out, range_rate_out,          valid & ready
//                       range_zero
//
// one item per cycle while the output is not stalled; path from input to output transfer:
// input, multiply, 33 square root stages, 34 divider stages, output register
// bearing runs in a parallel cordic pipeline padded to the same depth
// all stages advance together; a stalled output holds the whole pipe, nothing is lost
// synchronous reset clears valid bits only
module cartesian_to_range_bearing_rate_core (
    input  logic i_clk,
    input  logic i_rst_n,
    c2r_in_if.sink    i_meas,
    c2r_out_if.source o_res
);
    import c2r_pkg::*;

    logic w_en;

    logic                     r_v0;
    logic signed [WORD_W-1:0] r_px;
    logic signed [WORD_W-1:0] r_py;
    logic signed [WORD_W-1:0] r_vx;
    logic signed [WORD_W-1:0] r_vy;

    logic                     r_v1;
    logic [PROD_W-1:0]        r_sqx;
    logic [PROD_W-1:0]        r_sqy;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic                     r_zero1;
    logic signed [WORD_W-1:0] r_px1;
    logic signed [WORD_W-1:0] r_py1;

    logic [WORD_W-1:0] w_ax;
    logic [WORD_W-1:0] w_ay;

    t_sq_out                  w_sq;
    t_div_out                 w_div;
    logic signed [BEAR_W-1:0] w_bear;
    logic [Q_W-1:0]           w_qmag;

    logic                     r_ov;
    logic [RHO_W-1:0]         r_range;
    logic signed [BEAR_W-1:0] r_bear;
    logic signed [RATE_W-1:0] r_rate;
    logic                     r_zero;

    assign w_en         = !r_ov || o_res.ready;
    assign i_meas.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_meas.valid;
            r_v1 <= r_v0;
        end
        if (w_en) begin
            r_px <= i_meas.pos_x;
            r_py <= i_meas.pos_y;
            r_vx <= i_meas.vel_x;
            r_vy <= i_meas.vel_y;
        end
    end

    assign w_ax = r_px[WORD_W-1] ? -r_px : r_px;
    assign w_ay = r_py[WORD_W-1] ? -r_py : r_py;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx   <= PROD_W'(w_ax) * PROD_W'(w_ax);
            r_sqy   <= PROD_W'(w_ay) * PROD_W'(w_ay);
            r_p1    <= PROD_W'(r_px) * PROD_W'(r_vx);
            r_p2    <= PROD_W'(r_py) * PROD_W'(r_vy);
            r_zero1 <= (r_px == '0) && (r_py == '0);
            r_px1   <= r_px;
            r_py1   <= r_py;
        end
    end

    c2r_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v1),
        .i_sq_x  (r_sqx),
        .i_sq_y  (r_sqy),
        .i_p1    (r_p1),
        .i_p2    (r_p2),
        .i_zero  (r_zero1),
        .o_sq    (w_sq)
    );

    c2r_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_sq    (w_sq),
        .o_div   (w_div)
    );

    c2r_cordic u_cordic (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_px      (r_px1),
        .i_py      (r_py1),
        .o_bearing (w_bear)
    );

    assign w_qmag = (w_div.sat || (w_div.quo > RATE_LIM)) ? RATE_LIM : w_div.quo;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_div.valid;
        end
        if (w_en) begin
            r_range <= w_div.rho;
            r_zero  <= w_div.zero;
            if (w_div.zero) begin
                r_bear <= '0;
                r_rate <= '0;
            end else begin
                r_bear <= w_bear;
                r_rate <= w_div.neg ? -$signed(w_qmag) : $signed(w_qmag);
            end
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.range_out      = r_range;
    assign o_res.bearing_out    = r_bear;
    assign o_res.range_rate_out = r_rate;
    assign o_res.range_zero     = r_zero;

endmodule

// File: verif/cartesian_to_range_bearing_rate_core_tb.sv
// cartesian_to_range_bearing_rate_core_tb: self-checking testbench of the cartesian to polar core
module cartesian_to_range_bearing_rate_core_tb;
    import c2r_pkg::*;

    typedef struct {
        logic [RHO_W-1:0]         range_v;
        logic signed [BEAR_W-1:0] bear_v;
        logic signed [RATE_W-1:0] rate_v;
        logic                     zero_v;
    } t_polar;

    typedef struct {
        logic signed [WORD_W-1:0] px, py, vx, vy;
        bit                       has_fixed;
        t_polar                   fixed;
    } t_meas_row;

    localparam int WATCHDOG_LIM = 5000;
    localparam int RAND_ITEMS   = 450;
    localparam int DRAIN_CYCLES = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    c2r_in_if  meas_if ();
    c2r_out_if res_if ();

    cartesian_to_range_bearing_rate_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_meas (meas_if.sink),
        .o_res  (res_if.source)
    );

    always #6 i_clk = ~i_clk;

    t_polar    polar_q[$];
    t_meas_row dir_rows[$];
    int        err_cnt = 0;
    int        got_cnt = 0;
    int        idle_cycles = 0;
    int        zero_seen = 0;
    bit        no_idle = 1'b0;
    bit        stim_done = 1'b0;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-(v + 1)) + 64'd1 : v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res = 0, b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint bearing_of(longint x, longint y);
        longint z = 0, t, nx;
        longint unsigned m;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI_Q30;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI_Q30;
            end
        end
        m = mag(x) > mag(y) ? mag(x) : mag(y);
        while (m < (64'd1 << 57)) begin
            m <<= 1; x *= 2; y *= 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z += longint'(ATAN_TAB[i]);
            end else begin
                nx = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z -= longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        z = shr_floor(z + (64'sd1 << (ANG_FRAC - OUT_FRAC - 1)), ANG_FRAC - OUT_FRAC);
        if (z > BEAR_LIM) z = BEAR_LIM;
        if (z < -BEAR_LIM) z = -BEAR_LIM;
        return z;
    endfunction

    function automatic t_polar polar_of(logic signed [WORD_W-1:0] px_i, py_i, vx_i, vy_i);
        t_polar r;
        longint px = px_i, py = py_i, vx = vx_i, vy = vy_i;
        longint unsigned ax = mag(px), ay = mag(py);
        longint unsigned rho = root_floor(ax * ax + ay * ay);
        longint p1 = px * vx, p2 = py * vy;
        longint unsigned m1 = mag(p1), m2 = mag(p2), dm, q;
        bit neg;
        longint rate = 0, bear = 0;
        bit z = (px == 0 && py == 0);
        if (rho > 64'hFFFFFFFF) rho = 64'hFFFFFFFF;
        if (!z) begin
            if ((p1 < 0) == (p2 < 0)) begin
                dm = m1 + m2; neg = p1 < 0;
            end else if (m1 >= m2) begin
                dm = m1 - m2; neg = p1 < 0;
            end else begin
                dm = m2 - m1; neg = p2 < 0;
            end
            q = rho != 0 ? dm / rho : 0;
            if (q > RATE_LIM) q = RATE_LIM;
            rate = neg ? -longint'(q) : longint'(q);
            bear = bearing_of(px, py);
        end
        r.range_v = rho[RHO_W-1:0];
        r.bear_v  = bear[BEAR_W-1:0];
        r.rate_v  = rate[RATE_W-1:0];
        r.zero_v  = z;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            1: return 32'($signed($urandom_range(0, 200)) - 100);
            2: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [WORD_W-1:0] px, py, vx, vy, input bit fx = 1'b0,
                           input logic [RHO_W-1:0] rg = '0, input int bg = 0,
                           input longint rt = 0, input bit zr = 1'b0);
        t_meas_row r;
        r.px = px; r.py = py; r.vx = vx; r.vy = vy; r.has_fixed = fx;
        r.fixed.range_v = rg; r.fixed.bear_v = bg[BEAR_W-1:0];
        r.fixed.rate_v = rt[RATE_W-1:0]; r.fixed.zero_v = zr;
        dir_rows.push_back(r);
    endtask

    task automatic send_meas(input t_meas_row r);
        while (!no_idle && $urandom_range(0, 99) < 14) begin
            meas_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        meas_if.valid <= 1'b1;
        meas_if.pos_x <= r.px;
        meas_if.pos_y <= r.py;
        meas_if.vel_x <= r.vx;
        meas_if.vel_y <= r.vy;
        polar_q.push_back(r.has_fixed ? r.fixed : polar_of(r.px, r.py, r.vx, r.vy));
        @(posedge i_clk);
        while (!meas_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        res_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 14);

    always @(posedge i_clk) begin
        if ((meas_if.valid && meas_if.ready) || (i_rst_n && res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_cnt <= got_cnt + 1;
            if (polar_q.size() == 0) begin
                err_cnt <= err_cnt + 1;
                if (err_cnt < 10) $display("unexpected result transfer");
            end else begin
                t_polar e;
                e = polar_q.pop_front();
                if (res_if.range_zero) zero_seen <= zero_seen + 1;
                if (res_if.range_out !== e.range_v || res_if.bearing_out !== e.bear_v ||
                    res_if.range_rate_out !== e.rate_v || res_if.range_zero !== e.zero_v) begin
                    err_cnt <= err_cnt + 1;
                    if (err_cnt < 10)
                        $display("mismatch: exp rng %h brg %h rate %h z %b, got %h %h %h %b",
                                 e.range_v, e.bear_v, e.rate_v, e.zero_v, res_if.range_out,
                                 res_if.bearing_out, res_if.range_rate_out, res_if.range_zero);
                end
            end
        end
        if (i_rst_n && idle_cycles >= WATCHDOG_LIM) begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_meas_row r;
        meas_if.valid = 1'b0;
        meas_if.pos_x = '0;
        meas_if.pos_y = '0;
        meas_if.vel_x = '0;
        meas_if.vel_y = '0;
        res_if.ready = 1'b0;
        // origin, axes, extremes and general points
        add_row(0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(0, 0, 32'h7FFFFFFF, 32'h80000000, 1, 0, 0, 0, 1);
        add_row(32'h00010000, 0, 32'h00010000, 0, 1, 32'h00010000, 0, 32'h00010000, 0);
        add_row(32'hFFFF0000, 0, 0, 0);
        add_row(0, 32'h00010000, 0, 32'h00010000);
        add_row(0, 32'hFFFF0000, 5, 7);
        add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_row(32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        add_row(1, 0, 32'h7FFFFFFF, 0);
        add_row(1, 1, 32'h80000000, 32'h80000000);
        add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        add_row(32'hFFFFFFFF, 1, 3, 32'hFFFFFFFD);
        add_row(32'h12345678, 32'hEDCBA988, 32'h0000FFFF, 32'hFFFF0001);
        add_row(32'h00030000, 32'h00040000, 32'hFFFD0000, 32'hFFFC0000);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (dir_rows[k]) send_meas(dir_rows[k]);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            no_idle = (n >= 150 && n < 250);
            r.px = rand_word(); r.py = rand_word(); r.vx = rand_word(); r.vy = rand_word();
            if ($urandom_range(0, 29) == 0) begin
                r.px = 0; r.py = 0;
            end
            r.has_fixed = 1'b0;
            send_meas(r);
        end
        no_idle = 1'b0;
        meas_if.valid <= 1'b0;
        stim_done = 1'b1;
        while (polar_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d results checked, %0d at the origin, including saturation and axis cases",
                 got_cnt, zero_seen);
        if (err_cnt == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: files.f
hdl/c2r_pkg.sv
hdl/c2r_in_if.sv
hdl/c2r_out_if.sv
hdl/c2r_sqrt.sv
hdl/c2r_div.sv
hdl/c2r_cordic.sv
hdl/cartesian_to_range_bearing_rate_core.sv
verif/cartesian_to_range_bearing_rate_core_tb.sv
